// ===== src/ipv4hb_pkg.sv =====
// ----------------------------------------------------------------------------
// ipv4hb_pkg
// Types and constants shared by the Ethernet/IPv4 header builder.
// ----------------------------------------------------------------------------
package ipv4hb_pkg;

  localparam int unsigned HdrBytes   = 34;
  localparam int unsigned CfgIdxW    = 2;
  localparam int unsigned CfgDataW   = 48;
  localparam int unsigned ByteIdxW   = 6;

  localparam logic [CfgIdxW-1:0]  CFG_SOURCE_MAC = 2'd0;
  localparam logic [CfgIdxW-1:0]  CFG_SOURCE_IP  = 2'd1;

  localparam logic [15:0] MAX_PAYLOAD   = 16'd65515;
  localparam logic [15:0] IP_HDR_LEN    = 16'd20;
  localparam logic [7:0]  ETH_TYPE_HI   = 8'h08;
  localparam logic [7:0]  ETH_TYPE_LO   = 8'h00;
  localparam logic [7:0]  VER_IHL       = 8'h45;
  localparam logic [7:0]  TOS           = 8'h00;
  localparam logic [7:0]  FLAGS_HI      = 8'h40;
  localparam logic [7:0]  FLAGS_LO      = 8'h00;
  localparam logic [7:0]  TTL           = 8'h80;
  // 0x4500 + 0x4000: the two fixed header words that hold no field
  localparam logic [19:0] CSUM_FIXED    = 20'h08500;

  localparam logic [ByteIdxW-1:0] LAST_IDX = ByteIdxW'(HdrBytes - 1);

  typedef struct packed {
    logic [47:0] dst_mac;
    logic [31:0] dest_ip;
    logic [7:0]  protocol;
    logic [15:0] payload_length;
  } in_t;

  typedef struct packed {
    logic [7:0] header_byte;
    logic       last_byte;
  } out_t;

  // one fully prepared header, handed from front to back
  typedef struct packed {
    logic [47:0] dst_mac;
    logic [47:0] source_mac;
    logic [15:0] total_length;
    logic [15:0] ident;
    logic [7:0]  protocol;
    logic [15:0] checksum;
    logic [31:0] source_ip;
    logic [31:0] dest_ip;
  } hdr_t;

  // push side of the queue between front and back
  typedef struct packed {
    logic valid;
    logic ready;
  } qlink_t;

endpackage

// ===== src/ipv4hb_front.sv =====
// ----------------------------------------------------------------------------
// ipv4hb_front
// Accepts requests, assigns identification, computes the header checksum.
// ----------------------------------------------------------------------------
module ipv4hb_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  ipv4hb_pkg::in_t     in_data,
  input  logic [47:0]         source_mac,
  input  logic [31:0]         source_ip,
  output ipv4hb_pkg::qlink_t  push,
  input  logic                push_ready,
  output ipv4hb_pkg::hdr_t    push_data
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_SUM,
    S_FOLD
  } state_t;

  state_t           state;
  logic [15:0]      ident_count;
  ipv4hb_pkg::hdr_t hdr;
  logic [19:0]      acc;
  logic [15:0]      plen_sat;
  logic [16:0]      fold1;
  logic [16:0]      fold2;
  logic             accept;
  logic             pushing;

  assign plen_sat = (in_data.payload_length > ipv4hb_pkg::MAX_PAYLOAD)
                  ? ipv4hb_pkg::MAX_PAYLOAD : in_data.payload_length;

  // end-around carry, twice
  assign fold1 = {1'b0, acc[15:0]} + {13'd0, acc[19:16]};
  assign fold2 = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};

  assign pushing  = (state == S_FOLD) && push_ready;
  assign in_ready = (state == S_IDLE) || pushing;
  assign accept   = in_valid && in_ready;

  assign push.valid = (state == S_FOLD);
  assign push.ready = push_ready;

  always_comb begin
    push_data          = hdr;
    push_data.checksum = ~fold2[15:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      ident_count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) state <= S_SUM;
        end
        S_SUM: begin
          state <= S_FOLD;
        end
        S_FOLD: begin
          if (accept) state <= S_SUM;
          else if (pushing) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
      if (accept) ident_count <= ident_count + 16'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr.dst_mac      <= in_data.dst_mac;
      hdr.source_mac   <= source_mac;
      hdr.total_length <= plen_sat + ipv4hb_pkg::IP_HDR_LEN;
      hdr.ident        <= ident_count;
      hdr.protocol     <= in_data.protocol;
      hdr.checksum     <= '0;
      hdr.source_ip    <= source_ip;
      hdr.dest_ip      <= in_data.dest_ip;
    end
    if (state == S_SUM) begin
      acc <= ipv4hb_pkg::CSUM_FIXED
           + {4'd0, hdr.total_length}
           + {4'd0, hdr.ident}
           + {4'd0, ipv4hb_pkg::TTL, hdr.protocol}
           + {4'd0, hdr.source_ip[31:16]}
           + {4'd0, hdr.source_ip[15:0]}
           + {4'd0, hdr.dest_ip[31:16]}
           + {4'd0, hdr.dest_ip[15:0]};
    end
  end

endmodule

// ===== src/ipv4hb_fifo.sv =====
// ----------------------------------------------------------------------------
// ipv4hb_fifo
// Short queue of prepared headers between front and back.
// ----------------------------------------------------------------------------
module ipv4hb_fifo #(
  parameter int unsigned DEPTH = 2
) (
  input  logic                clk,
  input  logic                rst,
  input  ipv4hb_pkg::qlink_t  push,
  output logic                push_ready,
  input  ipv4hb_pkg::hdr_t    push_data,
  output logic                pop_valid,
  input  logic                pop,
  output ipv4hb_pkg::hdr_t    pop_data
);

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  ipv4hb_pkg::hdr_t  entries [DEPTH];
  logic [PtrW-1:0]   wr_ptr;
  logic [PtrW-1:0]   rd_ptr;
  logic [CntW-1:0]   count;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (count != CntW'(DEPTH));
  assign pop_valid  = (count != '0);
  assign pop_data   = entries[rd_ptr];
  assign do_push    = push.valid && push.ready;
  assign do_pop     = pop && pop_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PtrW'(DEPTH - 1)) ? '0 : wr_ptr + PtrW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PtrW'(DEPTH - 1)) ? '0 : rd_ptr + PtrW'(1);
      end
      if (do_push && !do_pop) count <= count + CntW'(1);
      else if (do_pop && !do_push) count <= count - CntW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_data;
  end

endmodule

// ===== src/ipv4hb_back.sv =====
// ----------------------------------------------------------------------------
// ipv4hb_back
// Serializes one prepared header into 34 bytes through an output register.
// ----------------------------------------------------------------------------
module ipv4hb_back (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 pop_valid,
  output logic                                 pop,
  input  ipv4hb_pkg::hdr_t                     pop_data,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output ipv4hb_pkg::out_t                     out_data
);

  ipv4hb_pkg::hdr_t                 cur;
  logic                             busy;
  logic [ipv4hb_pkg::ByteIdxW-1:0]  idx;
  logic                             advance;
  logic                             emit;
  logic                             at_last;
  logic [7:0]                       sel_byte;

  assign advance = !out_valid || out_ready;
  assign emit    = advance && busy;
  assign at_last = (idx == ipv4hb_pkg::LAST_IDX);
  assign pop     = pop_valid && (!busy || (emit && at_last));

  always_comb begin
    case (idx)
      6'd0:  sel_byte = cur.dst_mac[47:40];
      6'd1:  sel_byte = cur.dst_mac[39:32];
      6'd2:  sel_byte = cur.dst_mac[31:24];
      6'd3:  sel_byte = cur.dst_mac[23:16];
      6'd4:  sel_byte = cur.dst_mac[15:8];
      6'd5:  sel_byte = cur.dst_mac[7:0];
      6'd6:  sel_byte = cur.source_mac[47:40];
      6'd7:  sel_byte = cur.source_mac[39:32];
      6'd8:  sel_byte = cur.source_mac[31:24];
      6'd9:  sel_byte = cur.source_mac[23:16];
      6'd10: sel_byte = cur.source_mac[15:8];
      6'd11: sel_byte = cur.source_mac[7:0];
      6'd12: sel_byte = ipv4hb_pkg::ETH_TYPE_HI;
      6'd13: sel_byte = ipv4hb_pkg::ETH_TYPE_LO;
      6'd14: sel_byte = ipv4hb_pkg::VER_IHL;
      6'd15: sel_byte = ipv4hb_pkg::TOS;
      6'd16: sel_byte = cur.total_length[15:8];
      6'd17: sel_byte = cur.total_length[7:0];
      6'd18: sel_byte = cur.ident[15:8];
      6'd19: sel_byte = cur.ident[7:0];
      6'd20: sel_byte = ipv4hb_pkg::FLAGS_HI;
      6'd21: sel_byte = ipv4hb_pkg::FLAGS_LO;
      6'd22: sel_byte = ipv4hb_pkg::TTL;
      6'd23: sel_byte = cur.protocol;
      6'd24: sel_byte = cur.checksum[15:8];
      6'd25: sel_byte = cur.checksum[7:0];
      6'd26: sel_byte = cur.source_ip[31:24];
      6'd27: sel_byte = cur.source_ip[23:16];
      6'd28: sel_byte = cur.source_ip[15:8];
      6'd29: sel_byte = cur.source_ip[7:0];
      6'd30: sel_byte = cur.dest_ip[31:24];
      6'd31: sel_byte = cur.dest_ip[23:16];
      6'd32: sel_byte = cur.dest_ip[15:8];
      6'd33: sel_byte = cur.dest_ip[7:0];
      default: sel_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy      <= 1'b0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) out_valid <= busy;
      // load the next header right behind the last byte of the current one
      if (pop) begin
        busy <= 1'b1;
        idx  <= '0;
      end else if (emit) begin
        if (at_last) busy <= 1'b0;
        idx <= idx + 6'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) cur <= pop_data;
    if (emit) begin
      out_data.header_byte <= sel_byte;
      out_data.last_byte   <= at_last;
    end
  end

endmodule

// ===== src/ipv4_header_builder_top.sv =====
// ----------------------------------------------------------------------------
// ipv4_header_builder_top
// Builds Ethernet + IPv4 headers with checksum, one byte per unstalled cycle.
// ----------------------------------------------------------------------------
//  port group | kind        | payload
//  in_*       | valid/ready | dst_mac, dest_ip, protocol, payload_length
//  out_*      | valid/ready | header_byte, last_byte
//  cfg_*      | write only  | source_mac (index 0), source_ip (index 1)
//
//  Each request yields 34 bytes; the byte serializer sets the rate, and the
//  front prepares later requests while earlier ones are still being sent.
//  The front registers the request, then the checksum sum, and pushes the
//  header with its checksum into the queue once the queue has room.
//  Up to QueueDepth headers wait between front and back; the front keeps
//  accepting while the output stalls until the queue is full. Synchronous
//  reset clears control state, identification count and cfg registers.
// ----------------------------------------------------------------------------
module ipv4_header_builder_top #(
  parameter int unsigned QueueDepth = 2
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  ipv4hb_pkg::in_t                    in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output ipv4hb_pkg::out_t                   out_data,
  input  logic                               cfg_write,
  input  logic [ipv4hb_pkg::CfgIdxW-1:0]     cfg_index,
  input  logic [ipv4hb_pkg::CfgDataW-1:0]    cfg_data
);

  logic [47:0]        source_mac;
  logic [31:0]        source_ip;
  ipv4hb_pkg::qlink_t push;
  logic               push_ready;
  ipv4hb_pkg::hdr_t   push_data;
  logic               pop_valid;
  logic               pop;
  ipv4hb_pkg::hdr_t   pop_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      source_mac <= '0;
      source_ip  <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        ipv4hb_pkg::CFG_SOURCE_MAC: source_mac <= cfg_data[47:0];
        ipv4hb_pkg::CFG_SOURCE_IP:  source_ip  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  ipv4hb_front u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .source_mac (source_mac),
    .source_ip  (source_ip),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  ipv4hb_fifo #(
    .DEPTH (QueueDepth)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop        (pop),
    .pop_data   (pop_data)
  );

  ipv4hb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .pop_valid (pop_valid),
    .pop       (pop),
    .pop_data  (pop_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

// ===== src/ipv4hb_checker.sv =====
// ----------------------------------------------------------------------------
// ipv4hb_checker
// Port-level checks on framing and ordering of header bytes.
// ----------------------------------------------------------------------------
module ipv4hb_checker (
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input ipv4hb_pkg::out_t out_data
);

  localparam logic [5:0] VerIhlPos = 6'd14;

  logic [5:0] byte_count;
  logic [7:0] pending;
  logic       in_acc;
  logic       out_acc;
  logic       frame_done;

  assign in_acc     = in_valid && in_ready;
  assign out_acc    = out_valid && out_ready;
  assign frame_done = out_acc && out_data.last_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
      pending    <= '0;
    end else begin
      if (out_acc) begin
        byte_count <= (byte_count == ipv4hb_pkg::LAST_IDX) ? '0 : byte_count + 6'd1;
      end
      if (in_acc && !frame_done) pending <= pending + 8'd1;
      else if (frame_done && !in_acc) pending <= pending - 8'd1;
    end
  end

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output transaction changed while stalled");

  a_last: assert property (@(posedge clk) disable iff (rst)
    out_acc |-> (out_data.last_byte == (byte_count == ipv4hb_pkg::LAST_IDX)))
    else $error("last_byte not on the 34th byte of a header");

  a_ver: assert property (@(posedge clk) disable iff (rst)
    out_acc && (byte_count == VerIhlPos) |-> (out_data.header_byte == ipv4hb_pkg::VER_IHL))
    else $error("version/IHL byte out of place");

  a_orphan: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (pending != 8'd0))
    else $error("output transaction with no request outstanding");

endmodule

bind ipv4_header_builder_top ipv4hb_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

// ===== bench/tb_ipv4_header_builder_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_ipv4_header_builder_top
// Self-checking bench for the Ethernet/IPv4 header builder. Requests go in
// through a valid/ready driver fed from a queue. Each accepted request is
// expanded here into its 34 expected header bytes: own copy of the address
// registers and the identification count, with the checksum folded
// locally. A monitor compares every output byte in order. Both sides idle at
// random. One stretch without idling runs the block at full rate.
// ----------------------------------------------------------------------------
module tb_ipv4_header_builder_top;

  localparam logic [ipv4hb_pkg::CfgIdxW-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [ipv4hb_pkg::CfgIdxW-1:0] CFG_SPARE_B = 2'd3;
  localparam logic [7:0]  PROTO_ICMP  = 8'd1;
  localparam logic [7:0]  PROTO_TCP   = 8'd6;
  localparam logic [7:0]  PROTO_UDP   = 8'd17;
  localparam logic [15:0] LEN_CLIP    = 16'd65515;
  localparam int          IDLE_PCT    = 23;
  localparam int          FULL_RATE_ITEMS = 60;
  localparam int          MAX_REPORTS = 40;

  logic clk = 1'b0;
  logic rst = 1'b1;

  logic                            in_valid  = 1'b0;
  logic                            in_ready;
  ipv4hb_pkg::in_t                 in_data   = '0;
  logic                            out_valid;
  logic                            out_ready = 1'b0;
  ipv4hb_pkg::out_t                out_data;
  logic                            cfg_write = 1'b0;
  logic [ipv4hb_pkg::CfgIdxW-1:0]  cfg_index = '0;
  logic [ipv4hb_pkg::CfgDataW-1:0] cfg_data  = '0;

  ipv4hb_pkg::in_t  pending_reqs[$];
  ipv4hb_pkg::out_t expected_bytes[$];
  logic [47:0]      own_mac;
  logic [31:0]      own_ip;
  logic [15:0]      ident_model;
  int               idle_pct;
  int               errors;
  int               reqs_done;
  int               bytes_checked;
  int               clipped_reqs;
  int               reg_writes;
  ipv4hb_pkg::out_t want;

  ipv4_header_builder_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Expand one request into its header bytes and advance the identification.
  function automatic void build_expected_header(ipv4hb_pkg::in_t req);
    logic [7:0]       hdr [ipv4hb_pkg::HdrBytes];
    logic [15:0]      plen;
    logic [15:0]      total;
    logic [15:0]      csum;
    logic [31:0]      acc;
    ipv4hb_pkg::out_t b;
    int               k;
    plen = req.payload_length;
    if (plen > LEN_CLIP) begin
      plen = LEN_CLIP;
      clipped_reqs++;
    end
    total = plen + 16'd20;
    for (k = 0; k < 6; k++) begin
      hdr[k]     = req.dst_mac[47 - 8*k -: 8];
      hdr[6 + k] = own_mac[47 - 8*k -: 8];
    end
    hdr[12] = 8'h08;
    hdr[13] = 8'h00;
    hdr[14] = 8'h45;
    hdr[15] = 8'h00;
    hdr[16] = total[15:8];
    hdr[17] = total[7:0];
    hdr[18] = ident_model[15:8];
    hdr[19] = ident_model[7:0];
    hdr[20] = 8'h40;
    hdr[21] = 8'h00;
    hdr[22] = 8'h80;
    hdr[23] = req.protocol;
    hdr[24] = 8'h00;
    hdr[25] = 8'h00;
    for (k = 0; k < 4; k++) begin
      hdr[26 + k] = own_ip[31 - 8*k -: 8];
      hdr[30 + k] = req.dest_ip[31 - 8*k -: 8];
    end
    acc = '0;
    for (k = 14; k < ipv4hb_pkg::HdrBytes; k += 2)
      acc += {16'h0000, hdr[k], hdr[k + 1]};
    // fold carries back in twice, then invert
    acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
    acc = {16'h0000, acc[15:0]} + {16'h0000, acc[31:16]};
    csum = ~acc[15:0];
    hdr[24] = csum[15:8];
    hdr[25] = csum[7:0];
    ident_model = ident_model + 16'd1;
    for (k = 0; k < ipv4hb_pkg::HdrBytes; k++) begin
      b.header_byte = hdr[k];
      b.last_byte   = (k == ipv4hb_pkg::HdrBytes - 1);
      expected_bytes.push_back(b);
    end
  endfunction

  function automatic ipv4hb_pkg::in_t make_req(logic [47:0] mac, logic [31:0] ip,
                                               logic [7:0] proto, logic [15:0] len);
    ipv4hb_pkg::in_t r;
    r.dst_mac        = mac;
    r.dest_ip        = ip;
    r.protocol       = proto;
    r.payload_length = len;
    return r;
  endfunction

  function automatic ipv4hb_pkg::in_t random_request();
    ipv4hb_pkg::in_t r;
    int unsigned     pick;
    r.dst_mac  = 48'({$urandom(), $urandom()});
    r.dest_ip  = $urandom();
    pick = $urandom_range(9);
    if (pick < 3)
      r.protocol = PROTO_TCP;
    else if (pick < 5)
      r.protocol = PROTO_UDP;
    else
      r.protocol = 8'($urandom_range(255));
    pick = $urandom_range(9);
    if (pick == 0)
      r.payload_length = 16'($urandom_range(65535, 65500));
    else if (pick == 1)
      r.payload_length = 16'($urandom_range(64));
    else
      r.payload_length = 16'($urandom_range(65535));
    return r;
  endfunction

  task automatic queue_random(int count);
    for (int i = 0; i < count; i++)
      pending_reqs.push_back(random_request());
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_valid || expected_bytes.size() != 0)
      @(negedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic write_reg(logic [ipv4hb_pkg::CfgIdxW-1:0] idx,
                           logic [ipv4hb_pkg::CfgDataW-1:0] value);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    reg_writes++;
    case (idx)
      ipv4hb_pkg::CFG_SOURCE_MAC: own_mac = value;
      ipv4hb_pkg::CFG_SOURCE_IP:  own_ip  = value[31:0];
      default: ;
    endcase
  endtask

  // Driver: predict on each accepted transaction, then offer the next one.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) begin
        build_expected_header(in_data);
        reqs_done++;
      end
      if (!in_valid || in_ready) begin
        if (pending_reqs.size() != 0 && $urandom_range(99) >= idle_pct) begin
          in_data  <= pending_reqs.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each output transaction with the oldest expected byte.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_bytes.size() == 0) begin
          if (errors < MAX_REPORTS)
            $display("%0t: unexpected byte %h last %b", $time,
                     out_data.header_byte, out_data.last_byte);
          errors++;
        end else begin
          want = expected_bytes.pop_front();
          bytes_checked++;
          if (out_data.header_byte !== want.header_byte) begin
            if (errors < MAX_REPORTS)
              $display("%0t: header_byte expected %h actual %h", $time,
                       want.header_byte, out_data.header_byte);
            errors++;
          end
          if (out_data.last_byte !== want.last_byte) begin
            if (errors < MAX_REPORTS)
              $display("%0t: last_byte expected %b actual %b", $time,
                       want.last_byte, out_data.last_byte);
            errors++;
          end
        end
      end
      out_ready <= ($urandom_range(99) >= idle_pct);
    end
  end

  initial begin
    own_mac       = '0;
    own_ip        = '0;
    ident_model   = '0;
    idle_pct      = IDLE_PCT;
    errors        = 0;
    reqs_done     = 0;
    bytes_checked = 0;
    clipped_reqs  = 0;
    reg_writes    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // registers still at their reset value of zero
    pending_reqs.push_back(make_req('0, '0, '0, '0));
    pending_reqs.push_back(make_req('1, '1, 8'hFF, 16'hFFFF));
    pending_reqs.push_back(make_req(48'h0102_0304_0506, 32'hC0A8_0001, PROTO_TCP, 16'd40));
    wait_drained();

    write_reg(ipv4hb_pkg::CFG_SOURCE_MAC, '1);
    write_reg(ipv4hb_pkg::CFG_SOURCE_IP, '1);
    // spare indexes must leave both registers alone
    write_reg(CFG_SPARE_A, 48'h1234_5678_9ABC);
    write_reg(CFG_SPARE_B, '0);
    pending_reqs.push_back(make_req('0, '0, PROTO_UDP, LEN_CLIP));
    pending_reqs.push_back(make_req('1, '1, PROTO_ICMP, LEN_CLIP + 16'd1));
    pending_reqs.push_back(make_req(48'hAAAA_AAAA_AAAA, 32'h5555_5555, 8'hAA, 16'h5555));
    pending_reqs.push_back(make_req(48'h5555_5555_5555, 32'hAAAA_AAAA, 8'h55, 16'hAAAA));
    pending_reqs.push_back(make_req(48'h00_1B_21_3C_4D_5E, 32'h0A00_0001, PROTO_TCP,
                                    LEN_CLIP - 16'd1));
    pending_reqs.push_back(make_req(48'hFFFF_FFFF_FFFF, 32'hE000_0001, PROTO_UDP, 16'd1));
    pending_reqs.push_back(make_req(48'h8000_0000_0001, 32'h8000_0001, 8'h80, 16'h8000));
    pending_reqs.push_back(make_req(48'h0000_0000_0001, 32'h0000_0001, 8'h01, 16'hFFEB));
    wait_drained();

    write_reg(ipv4hb_pkg::CFG_SOURCE_MAC, '0);
    write_reg(ipv4hb_pkg::CFG_SOURCE_IP, 48'hFFFF_0000_0000);
    pending_reqs.push_back(make_req(48'h0242_AC11_0002, 32'hFFFF_FFFF, PROTO_TCP, 16'd0));
    pending_reqs.push_back(make_req(48'h0242_AC11_0003, 32'h0000_0000, PROTO_UDP, 16'hFFF0));
    wait_drained();

    write_reg(ipv4hb_pkg::CFG_SOURCE_MAC, 48'({$urandom(), $urandom()}));
    write_reg(ipv4hb_pkg::CFG_SOURCE_IP, 48'({$urandom(), $urandom()}));
    queue_random(100);
    wait_drained();
    queue_random(100);
    wait_drained();

    // stretch at full rate on both sides
    idle_pct = 0;
    write_reg(ipv4hb_pkg::CFG_SOURCE_IP, 48'($urandom()));
    queue_random(FULL_RATE_ITEMS);
    wait_drained();
    idle_pct = IDLE_PCT;

    write_reg(ipv4hb_pkg::CFG_SOURCE_MAC, 48'({$urandom(), $urandom()}));
    write_reg(ipv4hb_pkg::CFG_SOURCE_IP, 48'({$urandom(), $urandom()}));
    queue_random(125);
    wait_drained();
    write_reg(ipv4hb_pkg::CFG_SOURCE_MAC, 48'({$urandom(), $urandom()}));
    queue_random(125);
    wait_drained();
    repeat (40) @(posedge clk);

    $display("checked %0d requests, %0d header bytes, %0d with payload length clipped",
             reqs_done, bytes_checked, clipped_reqs);
    $display("%0d register writes, spare indexes included; one full-rate stretch",
             reg_writes);
    if (errors == 0) begin
      $display("tb_ipv4_header_builder_top: PASS");
    end else begin
      $display("%0d mismatches", errors);
      $display("tb_ipv4_header_builder_top: FAIL");
    end
    $finish;
  end

  initial begin
    #100_000_000;
    $display("timeout: %0d bytes still expected", expected_bytes.size());
    $display("tb_ipv4_header_builder_top: FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
src/ipv4hb_pkg.sv
src/ipv4hb_front.sv
src/ipv4hb_fifo.sv
src/ipv4hb_back.sv
src/ipv4_header_builder_top.sv
src/ipv4hb_checker.sv
bench/tb_ipv4_header_builder_top.sv
